[hdl/histogram_median_filter_assert.svh]
`ifndef HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH
`define HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH

// implication checked at the same edge
`define HMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hmf: check failed");

// implication checked at the next edge
`define HMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hmf: check failed");

`endif

[hdl/hmf_pkg.sv]
package hmf_pkg;

  localparam int BINS  = 16;
  localparam int BIN_W = 4;
  localparam int CNT_W = 16;
  localparam int PIX_W = 8;
  localparam int SUM_W = 20;
  localparam int RANK_W = 12;
  localparam int ROW_W = 13;

  typedef logic [BINS-1:0][CNT_W-1:0] hist_row_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_STORE,
    OP_RD_REM,
    OP_RD_ADD,
    OP_RD_HIST,
    OP_UPD1,
    OP_UPD2,
    OP_INIT,
    OP_RANGE,
    OP_CSUM_START,
    OP_FSUM_START,
    OP_SUM_RUN,
    OP_CSCAN,
    OP_FSCAN,
    OP_EMIT,
    OP_ADV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   fine;
  } dp_cmd_t;

  typedef struct packed {
    logic ignore;
    logic first_row;
    logic split_fine;
    logic init_end;
    logic emit_none;
    logic sum_done;
    logic scan_found;
    logic scan_end;
    logic out_free;
    logic run_end;
  } dp_status_t;

endpackage

[hdl/histogram_median_filter.sv]
// Square-window rank (median) filter over a raster pixel stream.
// Input channel (in_valid / in_stall): one beat is a pixel in raster order
// (mode 0) or a bottom flush tick (mode 1) once the last row is in.
// Output channel (out_valid / out_stall): one beat per filtered pixel with
// its row and column; last marks the final result caused by an input beat.
// Configuration is written on cfg_valid / cfg_ready; the user must write it
// only while the block is idle, which the block itself does not enforce;
// width, height and radius writes restart the frame.
// Each input beat updates the column histograms, with a further fine row write
// when the removed and added pixels fall in different coarse bins (the first
// row instead rebuilds them over 16 fine rows); each result adds window sums
// (one histogram memory read per window column, coarse then fine), bin scans
// and an emit step. A beat with no result costs only the update.
// A result sits in the output register; the block takes its next input while
// the receiver stalls, but holds the next result until that register frees.
// Reset returns the controller state, configuration, output valid flag and
// stream position to their defaults; no clearing pass is run, since the first
// row of each frame rewrites every column histogram before it is read.
module histogram_median_filter import hmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  median,
  output logic [11:0]       out_row,
  output logic [10:0]       out_column,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  hmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  hmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .pixel      (pixel),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .median     (median),
    .out_row    (out_row),
    .out_column (out_column),
    .last       (last)
  );

endmodule

[hdl/hmf_ctrl.sv]
module hmf_ctrl import hmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_RREM,
    S_RADD,
    S_HIST,
    S_UPD1,
    S_UPD2,
    S_INIT,
    S_RANGE,
    S_CINIT,
    S_CSUM,
    S_CSCAN,
    S_FINIT,
    S_FSUM,
    S_FSCAN,
    S_EMIT,
    S_ADV
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.fine   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = OP_STORE;
        if (status.ignore) begin
          state_next = S_IDLE;
        end else if (status.first_row) begin
          state_next = S_INIT;
        end else begin
          state_next = S_RREM;
        end
      end
      S_RREM: begin
        cmd.op     = OP_RD_REM;
        state_next = S_RADD;
      end
      S_RADD: begin
        cmd.op     = OP_RD_ADD;
        state_next = S_HIST;
      end
      S_HIST: begin
        cmd.op     = OP_RD_HIST;
        state_next = S_UPD1;
      end
      S_UPD1: begin
        cmd.op     = OP_UPD1;
        state_next = status.split_fine ? S_UPD2 : S_RANGE;
      end
      S_UPD2: begin
        cmd.op     = OP_UPD2;
        state_next = S_RANGE;
      end
      S_INIT: begin
        cmd.op = OP_INIT;
        if (status.init_end) state_next = S_RANGE;
      end
      S_RANGE: begin
        cmd.op     = OP_RANGE;
        state_next = status.emit_none ? S_ADV : S_CINIT;
      end
      S_CINIT: begin
        cmd.op     = OP_CSUM_START;
        state_next = S_CSUM;
      end
      S_CSUM: begin
        cmd.op = OP_SUM_RUN;
        if (status.sum_done) state_next = S_CSCAN;
      end
      S_CSCAN: begin
        cmd.op = OP_CSCAN;
        if (status.scan_found) begin
          state_next = S_FINIT;
        end else if (status.scan_end) begin
          state_next = S_EMIT;
        end
      end
      S_FINIT: begin
        cmd.op     = OP_FSUM_START;
        cmd.fine   = 1'b1;
        state_next = S_FSUM;
      end
      S_FSUM: begin
        cmd.op   = OP_SUM_RUN;
        cmd.fine = 1'b1;
        if (status.sum_done) state_next = S_FSCAN;
      end
      S_FSCAN: begin
        cmd.op = OP_FSCAN;
        if (status.scan_found || status.scan_end) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (status.out_free) state_next = status.run_end ? S_ADV : S_CINIT;
      end
      S_ADV: begin
        cmd.op     = OP_ADV;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/hmf_datapath.sv]
module hmf_datapath import hmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic              mode,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  median,
  output logic [11:0]       out_row,
  output logic [10:0]       out_column,
  output logic              last
);

  localparam int XW       = $clog2(MAX_WIDTH);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int RW       = $clog2(MAX_RADIUS + 1);
  localparam int RING     = 2 * MAX_RADIUS + 2;
  localparam int SLW      = $clog2(RING);
  localparam int RS_DEPTH = RING * MAX_WIDTH;
  localparam int RSA_W    = $clog2(RS_DEPTH);
  localparam int FA_W     = XW + BIN_W;
  localparam int SW       = ((XW > RW) ? XW : RW) + 3;
  localparam int YSW      = ROW_W + 1;
  localparam int CW       = RW + 2;
  localparam int W_RST    = (2048 > MAX_WIDTH) ? MAX_WIDTH : 2048;
  localparam int R_RST    = 1;

  localparam logic [2:0] CFG_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_RADIUS    = 3'd2;
  localparam logic [2:0] CFG_RANK      = 3'd3;
  localparam logic [2:0] CFG_PAD_LEFT  = 3'd4;
  localparam logic [2:0] CFG_PAD_RIGHT = 3'd5;

  // configuration
  logic [WW-1:0]     w;
  logic [ROW_W-1:0]  h;
  logic [RW-1:0]     r;
  logic [RANK_W-1:0] rank;
  logic              pad_left;
  logic              pad_right;

  // stream position and ring rows
  logic [XW-1:0]     x;
  logic [ROW_W-1:0]  y;
  logic [SLW-1:0]    add_slot;
  logic [SLW-1:0]    rem_slot;

  logic              mode_l;
  logic [PIX_W-1:0]  pix_l;
  logic [PIX_W-1:0]  v_rem;
  logic [PIX_W-1:0]  v_add;
  logic [BIN_W-1:0]  kinit;

  logic signed [SW-1:0] t;
  logic [CW-1:0]        cnt;
  logic                 pend;
  hist_row_t            acc;
  logic [BIN_W-1:0]     j;
  logic [BIN_W-1:0]     kfound;
  logic [SUM_W-1:0]     sum;
  logic [PIX_W-1:0]     med;
  logic signed [SW-1:0] c;
  logic signed [SW-1:0] chi;

  // memories
  logic [PIX_W-1:0] row_mem [RS_DEPTH];
  hist_row_t        coarse_mem [MAX_WIDTH];
  hist_row_t        fine_mem [MAX_WIDTH * BINS];

  logic             rs_we, rs_re;
  logic [RSA_W-1:0] rs_waddr, rs_raddr;
  logic [PIX_W-1:0] rs_rdata;
  logic             c_we, c_re;
  logic [XW-1:0]    c_waddr, c_raddr;
  hist_row_t        c_wdata, c_rdata;
  logic             f_we, f_re;
  logic [FA_W-1:0]  f_waddr, f_raddr;
  hist_row_t        f_wdata, f_rdata;

  // combinational helpers
  logic signed [SW-1:0]  ws, rs, xs, wm1, lo0, lo1, lo, hi0, hi, tcl;
  logic signed [YSW-1:0] dr;
  logic [XW-1:0]         col;
  logic [CW-1:0]         cnt_full;
  logic                  issue;
  logic [SUM_W-1:0]      s;
  logic                  found;
  logic                  out_free;
  logic                  run_end;
  logic [CNT_W-1:0]      init_cnt;
  logic                  same_fine;
  hist_row_t             c_upd, f_upd1, f_upd2, c_init, f_init;
  logic [RSA_W-1:0]      add_addr, rem_addr;
  logic [ROW_W-1:0]      ny;
  logic                  x_wrap;
  logic                  y_wrap;
  logic [WW-1:0]         w_sat;
  logic [ROW_W-1:0]      h_sat;
  logic [RW-1:0]         r_sat;

  assign ws  = SW'(w);
  assign rs  = SW'(r);
  assign xs  = SW'(x);
  assign wm1 = ws - SW'(1);
  assign dr  = YSW'(y) - YSW'(r);

  always_comb begin
    lo0 = xs - rs;
    lo1 = (lo0 < 0) ? SW'(0) : lo0;
    lo  = (!pad_left && lo1 < rs) ? rs : lo1;
    hi0 = (xs == wm1) ? wm1 : lo0;
    hi  = (!pad_right && hi0 > wm1 - rs) ? wm1 - rs : hi0;
  end

  assign tcl      = (t < 0) ? SW'(0) : ((t > wm1) ? wm1 : t);
  assign col      = XW'(tcl);
  assign cnt_full = CW'({r, 1'b1});
  assign init_cnt = CNT_W'({r, 1'b1});
  assign issue    = (cmd.op == OP_SUM_RUN) && (cnt != cnt_full);
  assign s        = sum + SUM_W'(acc[j]);
  assign found    = s > SUM_W'(rank);
  assign out_free = !out_valid || !out_stall;
  assign run_end  = (c == chi);
  assign same_fine = (v_rem[PIX_W-1:BIN_W] == v_add[PIX_W-1:BIN_W]);

  assign add_addr = RSA_W'(add_slot) * RSA_W'(MAX_WIDTH) + RSA_W'(x);
  assign rem_addr = RSA_W'(rem_slot) * RSA_W'(MAX_WIDTH) + RSA_W'(x);

  assign status.ignore     = (y < h) && mode_l;
  assign status.first_row  = (y == '0);
  assign status.split_fine = !same_fine;
  assign status.init_end   = (kinit == BIN_W'(BINS - 1));
  assign status.emit_none  = (dr < 0) || (lo > hi);
  assign status.sum_done   = (cnt == cnt_full) && !pend;
  assign status.scan_found = found;
  assign status.scan_end   = (j == BIN_W'(BINS - 1));
  assign status.out_free   = out_free;
  assign status.run_end    = run_end;

  // lane updates of one histogram row
  always_comb begin
    for (int i = 0; i < BINS; i++) begin
      c_upd[i] = c_rdata[i];
      if (BIN_W'(i) == v_rem[PIX_W-1:BIN_W]) c_upd[i] = c_upd[i] - CNT_W'(1);
      if (BIN_W'(i) == v_add[PIX_W-1:BIN_W]) c_upd[i] = c_upd[i] + CNT_W'(1);
      f_upd1[i] = f_rdata[i];
      if (BIN_W'(i) == v_rem[BIN_W-1:0]) f_upd1[i] = f_upd1[i] - CNT_W'(1);
      if (same_fine && BIN_W'(i) == v_add[BIN_W-1:0]) f_upd1[i] = f_upd1[i] + CNT_W'(1);
      f_upd2[i] = f_rdata[i];
      if (BIN_W'(i) == v_add[BIN_W-1:0]) f_upd2[i] = f_upd2[i] + CNT_W'(1);
      c_init[i] = (BIN_W'(i) == pix_l[PIX_W-1:BIN_W]) ? init_cnt : '0;
      f_init[i] = (BIN_W'(i) == pix_l[BIN_W-1:0] && kinit == pix_l[PIX_W-1:BIN_W]) ?
                  init_cnt : '0;
    end
  end

  // memory port control
  always_comb begin
    rs_we = 1'b0; rs_re = 1'b0; rs_waddr = add_addr; rs_raddr = rem_addr;
    c_we = 1'b0; c_re = 1'b0; c_waddr = x; c_raddr = x; c_wdata = c_upd;
    f_we = 1'b0; f_re = 1'b0;
    f_waddr = {x, v_rem[PIX_W-1:BIN_W]};
    f_raddr = {x, v_rem[PIX_W-1:BIN_W]};
    f_wdata = f_upd1;
    case (cmd.op)
      OP_STORE: rs_we = (y < h) && !mode_l;
      OP_RD_REM: rs_re = 1'b1;
      OP_RD_ADD: begin
        rs_re    = 1'b1;
        rs_raddr = add_addr;
      end
      OP_RD_HIST: begin
        c_re = 1'b1;
        f_re = 1'b1;
      end
      OP_UPD1: begin
        c_we    = 1'b1;
        f_we    = 1'b1;
        f_re    = 1'b1;
        f_raddr = {x, v_add[PIX_W-1:BIN_W]};
      end
      OP_UPD2: begin
        f_we    = 1'b1;
        f_waddr = {x, v_add[PIX_W-1:BIN_W]};
        f_wdata = f_upd2;
      end
      OP_INIT: begin
        c_we    = 1'b1;
        c_wdata = c_init;
        f_we    = 1'b1;
        f_waddr = {x, kinit};
        f_wdata = f_init;
      end
      OP_SUM_RUN: begin
        c_raddr = col;
        f_raddr = {col, kfound};
        c_re    = issue && !cmd.fine;
        f_re    = issue && cmd.fine;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rs_we) row_mem[rs_waddr] <= pix_l;
    if (rs_re) rs_rdata <= row_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) coarse_mem[c_waddr] <= c_wdata;
    if (c_re) c_rdata <= coarse_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fine_mem[f_waddr] <= f_wdata;
    if (f_re) f_rdata <= fine_mem[f_raddr];
  end

  // register write saturation
  always_comb begin
    if (cfg_data[11:0] == '0) begin
      w_sat = WW'(1);
    end else if (32'(cfg_data[11:0]) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(cfg_data[11:0]);
    end
    if (cfg_data == '0) begin
      h_sat = ROW_W'(1);
    end else if (cfg_data > 13'd4096) begin
      h_sat = 13'd4096;
    end else begin
      h_sat = cfg_data;
    end
    if (cfg_data[4:0] == '0) begin
      r_sat = RW'(1);
    end else if (32'(cfg_data[4:0]) > MAX_RADIUS) begin
      r_sat = RW'(MAX_RADIUS);
    end else begin
      r_sat = RW'(cfg_data[4:0]);
    end
  end

  assign ny     = y + ROW_W'(1);
  assign x_wrap = (WW'(x) + WW'(1)) >= w;
  assign y_wrap = (YSW'(ny) > YSW'(h) - YSW'(1) + YSW'(r));

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w         <= WW'(W_RST);
      h         <= 13'd1080;
      r         <= RW'(R_RST);
      rank      <= 12'd4;
      pad_left  <= 1'b1;
      pad_right <= 1'b1;
      x         <= '0;
      y         <= '0;
      add_slot  <= '0;
      rem_slot  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_ADV) begin
        if (x_wrap) begin
          x <= '0;
          if (y_wrap) begin
            y        <= '0;
            add_slot <= '0;
            rem_slot <= '0;
          end else begin
            y <= ny;
            if (ny < h) begin
              add_slot <= (add_slot == SLW'(RING - 1)) ? '0 : add_slot + SLW'(1);
            end
            if (ny > ROW_W'({r, 1'b1})) begin
              rem_slot <= (rem_slot == SLW'(RING - 1)) ? '0 : rem_slot + SLW'(1);
            end
          end
        end else begin
          x <= x + XW'(1);
        end
      end
      if (cmd.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WIDTH: begin
            w <= w_sat;
            x <= '0; y <= '0; add_slot <= '0; rem_slot <= '0;
          end
          CFG_HEIGHT: begin
            h <= h_sat;
            x <= '0; y <= '0; add_slot <= '0; rem_slot <= '0;
          end
          CFG_RADIUS: begin
            r <= r_sat;
            x <= '0; y <= '0; add_slot <= '0; rem_slot <= '0;
          end
          CFG_RANK:      rank <= cfg_data[11:0];
          CFG_PAD_LEFT:  pad_left <= cfg_data[0];
          CFG_PAD_RIGHT: pad_right <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        mode_l <= mode;
        pix_l  <= pixel;
      end
      OP_STORE:   kinit <= '0;
      OP_RD_ADD:  v_rem <= rs_rdata;
      OP_RD_HIST: v_add <= rs_rdata;
      OP_INIT:    kinit <= kinit + BIN_W'(1);
      OP_RANGE: begin
        c   <= lo;
        chi <= hi;
      end
      OP_CSUM_START: begin
        acc  <= '0;
        t    <= c - rs;
        cnt  <= '0;
        pend <= 1'b0;
        sum  <= '0;
        j    <= '0;
      end
      OP_FSUM_START: begin
        acc  <= '0;
        t    <= c - rs;
        cnt  <= '0;
        pend <= 1'b0;
        j    <= '0;
      end
      OP_SUM_RUN: begin
        if (issue) begin
          t   <= t + SW'(1);
          cnt <= cnt + CW'(1);
        end
        pend <= issue;
        if (pend) begin
          for (int i = 0; i < BINS; i++) begin
            acc[i] <= acc[i] + (cmd.fine ? f_rdata[i] : c_rdata[i]);
          end
        end
      end
      OP_CSCAN: begin
        if (found) begin
          kfound <= j;
        end else begin
          sum <= s;
          j   <= j + BIN_W'(1);
          if (status.scan_end) med <= '1;
        end
      end
      OP_FSCAN: begin
        sum <= s;
        if (found) begin
          med <= {kfound, j};
        end else begin
          j <= j + BIN_W'(1);
          if (status.scan_end) med <= '1;
        end
      end
      OP_EMIT: begin
        if (out_free && !run_end) c <= c + SW'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT && out_free) begin
      median     <= med;
      out_row    <= 12'(dr);
      out_column <= 11'(c);
      last       <= run_end;
    end
  end

endmodule

[hdl/hmf_checker.sv]
`include "histogram_median_filter_assert.svh"

module hmf_checker import hmf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] median,
  input logic [11:0]      out_row,
  input logic [10:0]      out_column,
  input logic             last
);

  logic [31:0] res_bits;

  assign res_bits = {median, out_row, out_column, last};

  // a stalled result beat holds
  `HMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_bits))

  // an accepted input keeps the block busy for at least the next cycle
  `HMF_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)

  // a taken result that is not the last one means the item is still in work
  `HMF_ASSERT_NEXT(a_more_results, out_valid && !out_stall && !last, in_stall)

  // no result right after reset
  `HMF_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

endmodule

bind histogram_median_filter hmf_checker u_hmf_checker (.*);
